/* hdl/ordered_list_engine_assert.svh */
// Assertion macros for the ordered list engine.
// Included by the top level; needs i_clk and i_rst_n in the including scope.
`ifndef ORDERED_LIST_ENGINE_ASSERT_SVH
`define ORDERED_LIST_ENGINE_ASSERT_SVH

// The consequence must hold in the same cycle as the condition.
`define OLE_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequence must hold in the cycle after the condition.
`define OLE_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/ole_pkg.sv */
// Shared types and codes of the ordered list engine.
// Used by ole_cell and ordered_list_engine; depends on nothing.
package ole_pkg;

    localparam int unsigned CMD_W   = 3;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned STAT_W  = 2;

    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_INSERT_AT  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_SEARCH     = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STAT_W-1:0] ST_POS   = 2'd3;

    // Per-cell control, built by the top level for each cell of the row.
    typedef struct packed {
        logic insert;     // an insert of any kind is carried out this cycle
        logic shift_fwd;  // the row shifts toward the front this cycle
        logic at_pos;     // this cell is the insert position
        logic above_pos;  // this cell lies behind the insert position
        logic live;       // this cell holds an entry of the list
    } t_cell_ctl;

endpackage

/* hdl/ordered_list_engine.sv */
// Top level of the ordered list engine: command decode, the row of cells and
// the result buffer. Depends on ole_pkg, ole_cell and ordered_list_engine_assert.svh.
//
// The ordered list engine keeps up to DEPTH signed 32-bit entries in a row of
// identical cells, index 0 at the front. Each request carries a command (push
// front, push back, pop front, pop back, insert at a position, or search for a
// value) and yields exactly one result with a status, a found flag and the
// entry count after the command. On the edge that accepts a request, every
// cell loads its new entry at once (from its own register, its front or back
// neighbor, or the incoming value), and a search compares the value in every
// live cell in parallel and ORs the matches across the row. The sustained
// rate is therefore one request per cycle while the input is not stalled.
// Results wait in an output register backed by a one-deep skid stage, so a
// stalled output does not hold off the next request; the input stalls only
// when both stages are full. Entries are not cleared by reset; a cell outside
// the current count is never looked at, so there is no clearing pass after
// reset.
module ordered_list_engine
    import ole_pkg::*;
#(
    parameter int unsigned DEPTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Request channel.
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [CMD_W-1:0]                     i_cmd,
    input  logic signed [VALUE_W-1:0]            i_value,
    input  logic [$clog2(DEPTH+1)-1:0]           i_position,
    // Result channel.
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [STAT_W-1:0]                    o_status,
    output logic                                 o_found,
    output logic [$clog2(DEPTH+1)-1:0]           o_entry_count
);

    localparam int unsigned CW = $clog2(DEPTH + 1);

    // Entry count of the list.
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;

    // Result computed for the request accepted this cycle.
    logic [STAT_W-1:0] w_status;
    logic              w_found;
    logic [CW-1:0]     w_pos;
    logic              w_insert;
    logic              w_shift_fwd;
    logic              w_in_acc;
    logic              w_out_acc;

    // Row of cells.
    logic signed [VALUE_W-1:0] w_entry [DEPTH];
    logic [DEPTH-1:0]          w_match;
    t_cell_ctl                 w_ctl   [DEPTH];

    // Output register and skid stage.
    logic              r_out_vld;
    logic [STAT_W-1:0] r_out_status;
    logic              r_out_found;
    logic [CW-1:0]     r_out_count;
    logic              r_skid_vld;
    logic [STAT_W-1:0] r_skid_status;
    logic              r_skid_found;
    logic [CW-1:0]     r_skid_count;

    assign o_in_stall = r_skid_vld;
    assign w_in_acc   = i_in_valid && !r_skid_vld;
    assign w_out_acc  = r_out_vld && !i_out_stall;

    // Command decode. The full check comes before the position check on an
    // insert, and pops on an empty list leave everything as it is.
    always_comb begin
        w_status    = ST_OK;
        w_found     = 1'b0;
        w_pos       = '0;
        w_insert    = 1'b0;
        w_shift_fwd = 1'b0;
        n_count     = r_count;
        unique case (i_cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT_AT: begin
                if (i_cmd == CMD_PUSH_FRONT) begin
                    w_pos = '0;
                end else if (i_cmd == CMD_PUSH_BACK) begin
                    w_pos = r_count;
                end else begin
                    w_pos = i_position;
                end
                if (r_count == CW'(DEPTH)) begin
                    w_status = ST_FULL;
                end else if (w_pos > r_count) begin
                    w_status = ST_POS;
                end else begin
                    w_insert = w_in_acc;
                    n_count  = r_count + CW'(1);
                end
            end
            CMD_POP_FRONT: begin
                if (r_count == '0) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_shift_fwd = w_in_acc;
                    n_count     = r_count - CW'(1);
                end
            end
            CMD_POP_BACK: begin
                if (r_count == '0) begin
                    w_status = ST_EMPTY;
                end else begin
                    n_count = r_count - CW'(1);
                end
            end
            CMD_SEARCH: begin
                w_found = |w_match;
            end
            default: begin
                w_status = ST_OK;
            end
        endcase
    end

    // Each cell gets its own view of the insert position and of the count.
    // Cell 0 has no front neighbor and the last cell no back neighbor; both are tied to
    // its own entry. Cell 0's is never selected, the last cell's only on a pop front.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [VALUE_W-1:0] w_left;
        logic signed [VALUE_W-1:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = w_entry[g];
        end else begin : g_mid_l
            assign w_left = w_entry[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign w_right = w_entry[g];
        end else begin : g_mid_r
            assign w_right = w_entry[g+1];
        end

        assign w_ctl[g].insert    = w_insert;
        assign w_ctl[g].shift_fwd = w_shift_fwd;
        assign w_ctl[g].at_pos    = (CW'(g) == w_pos);
        assign w_ctl[g].above_pos = (CW'(g) > w_pos);
        assign w_ctl[g].live      = (CW'(g) < r_count);

        ole_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl[g]),
            .i_value (i_value),
            .i_left  (w_left),
            .i_right (w_right),
            .o_entry (w_entry[g]),
            .o_match (w_match[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_in_acc) begin
            r_count <= n_count;
        end
    end

    // Result buffer. A new result goes to the output register when it is
    // free or being drained with nothing in the skid stage; otherwise it
    // waits in the skid stage, which is only ever loaded while empty.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            if (w_out_acc) begin
                if (r_skid_vld) begin
                    r_out_vld  <= 1'b1;
                    r_skid_vld <= w_in_acc;
                end else begin
                    r_out_vld  <= w_in_acc;
                end
            end else if (r_out_vld) begin
                if (w_in_acc) begin
                    r_skid_vld <= 1'b1;
                end
            end else begin
                r_out_vld <= w_in_acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_acc && r_skid_vld) begin
            r_out_status <= r_skid_status;
            r_out_found  <= r_skid_found;
            r_out_count  <= r_skid_count;
        end else if (w_in_acc && (w_out_acc || !r_out_vld)) begin
            r_out_status <= w_status;
            r_out_found  <= w_found;
            r_out_count  <= n_count;
        end
        if (w_in_acc && (r_skid_vld || (r_out_vld && !w_out_acc))) begin
            r_skid_status <= w_status;
            r_skid_found  <= w_found;
            r_skid_count  <= n_count;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_status      = r_out_status;
    assign o_found       = r_out_found;
    assign o_entry_count = r_out_count;

`include "ordered_list_engine_assert.svh"

    // The count never runs past the capacity of the row.
    `OLE_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CW'(DEPTH), "entry count exceeds DEPTH")
    // The skid stage holds a result only behind a waiting output register.
    `OLE_ASSERT_NOW(a_skid_order, r_skid_vld, r_out_vld, "skid stage full with output empty")
    // A pop from a non-empty list removes exactly one entry.
    `OLE_ASSERT_NEXT(a_pop_count,
        i_rst_n && w_in_acc && (i_cmd == CMD_POP_FRONT || i_cmd == CMD_POP_BACK) && r_count != '0,
        r_count == $past(r_count) - CW'(1), "pop did not remove one entry")
    // A search leaves the list as it was.
    `OLE_ASSERT_NEXT(a_search_keep, i_rst_n && w_in_acc && i_cmd == CMD_SEARCH,
        r_count == $past(r_count), "search changed the entry count")

endmodule

/* hdl/ole_cell.sv */
// One cell of the list row: holds one entry and compares it with the search value.
// Depends on ole_pkg for the control struct.
module ole_cell
    import ole_pkg::*;
(
    input  logic                      i_clk,
    input  t_cell_ctl                 i_ctl,
    input  logic signed [VALUE_W-1:0] i_value,
    input  logic signed [VALUE_W-1:0] i_left,
    input  logic signed [VALUE_W-1:0] i_right,
    output logic signed [VALUE_W-1:0] o_entry,
    output logic                      o_match
);

    logic signed [VALUE_W-1:0] r_entry;
    logic signed [VALUE_W-1:0] n_entry;

    always_comb begin
        priority if (i_ctl.insert && i_ctl.at_pos) begin
            n_entry = i_value;
        end else if (i_ctl.insert && i_ctl.above_pos) begin
            n_entry = i_left;
        end else if (i_ctl.shift_fwd) begin
            n_entry = i_right;
        end else begin
            n_entry = r_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    assign o_match = i_ctl.live && (r_entry == i_value);

endmodule

/* dv/ordered_list_engine_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for ordered_list_engine: directed corner requests, then random traffic.
// Depends on ole_pkg and the ordered_list_engine RTL; the expected results come from a list kept here.

module ordered_list_engine_tb;
    import ole_pkg::*;

    localparam int unsigned DEPTH = 16;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    // Codes 6 and 7 are not used by the block and must act as no operation.
    localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

    localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    localparam int unsigned RANDOM_REQUESTS = 1000;
    localparam int unsigned PHASE_LEN       = 200;
    localparam int unsigned CYCLE_LIMIT     = 400000;

    // Idling plan per random phase: 0 none, 1 light, 2 heavy.
    localparam int unsigned GAP_PLAN[5]   = '{1, 0, 2, 1, 0};
    localparam int unsigned STALL_PLAN[5] = '{1, 0, 1, 2, 2};

    // Keeps its own copy of the list, works out the result of each accepted request
    // and checks the results of the block in order against it.
    class t_scoreboard;
        typedef struct {
            logic [STAT_W-1:0] status;
            logic              found;
            logic [CNT_W-1:0]  count;
        } t_outcome;

        logic signed [VALUE_W-1:0] row[$];
        t_outcome                  outcomes[$];
        int unsigned               n_errors = 0;
        int unsigned               n_checked = 0;

        task report_mismatch(string what);
            $display("MISMATCH at %0t: %s", $time, what);
            n_errors++;
        endtask

        function int unsigned entry_count();
            return row.size();
        endfunction

        function int unsigned pending();
            return outcomes.size();
        endfunction

        // A value currently held in the list (a random one if it is empty), so that searches hit often.
        function logic signed [VALUE_W-1:0] stored_value();
            if (row.size() == 0)
                return $urandom;
            return row[$urandom_range(0, row.size() - 1)];
        endfunction

        function void note_request(logic [CMD_W-1:0] cmd,
                                   logic signed [VALUE_W-1:0] value,
                                   logic [CNT_W-1:0] position);
            t_outcome    o;
            int unsigned at;
            o.status = ST_OK;
            o.found  = 1'b0;
            case (cmd)
                CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT_AT: begin
                    // A full list drops the value before the position is looked at.
                    if (row.size() >= DEPTH) begin
                        o.status = ST_FULL;
                    end else begin
                        if (cmd == CMD_PUSH_FRONT)
                            at = 0;
                        else if (cmd == CMD_PUSH_BACK)
                            at = row.size();
                        else
                            at = position;
                        if (at > row.size())
                            o.status = ST_POS;
                        else
                            row.insert(at, value);
                    end
                end
                CMD_POP_FRONT: begin
                    if (row.size() == 0)
                        o.status = ST_EMPTY;
                    else
                        row.delete(0);
                end
                CMD_POP_BACK: begin
                    if (row.size() == 0)
                        o.status = ST_EMPTY;
                    else
                        row.delete(row.size() - 1);
                end
                CMD_SEARCH: begin
                    foreach (row[i])
                        if (row[i] == value)
                            o.found = 1'b1;
                end
                default: begin
                    // Spare codes change nothing.
                end
            endcase
            o.count = CNT_W'(row.size());
            outcomes.insert(outcomes.size(), o);
        endfunction

        task check_result(logic [STAT_W-1:0] status, logic found, logic [CNT_W-1:0] count);
            t_outcome want;
            if (outcomes.size() == 0) begin
                report_mismatch($sformatf("result with no request pending (status %0d count %0d)",
                                          status, count));
                return;
            end
            want = outcomes[0];
            outcomes.delete(0);
            n_checked++;
            if (status !== want.status)
                report_mismatch($sformatf("result %0d: status %0d, expected %0d",
                                          n_checked, status, want.status));
            if (found !== want.found)
                report_mismatch($sformatf("result %0d: found %0b, expected %0b",
                                          n_checked, found, want.found));
            if (count !== want.count)
                report_mismatch($sformatf("result %0d: entry count %0d, expected %0d",
                                          n_checked, count, want.count));
        endtask
    endclass

    logic                     i_clk         = 1'b0;
    logic                     i_rst_n       = 1'b0;
    logic                     i_in_valid    = 1'b0;
    logic                     o_in_stall;
    logic [CMD_W-1:0]         i_cmd         = CMD_PUSH_FRONT;
    logic signed [VALUE_W-1:0] i_value      = '0;
    logic [CNT_W-1:0]         i_position    = '0;
    logic                     o_out_valid;
    logic                     i_out_stall   = 1'b0;
    logic [STAT_W-1:0]        o_status;
    logic                     o_found;
    logic [CNT_W-1:0]         o_entry_count;

    t_scoreboard sb = new();

    int unsigned gap_mode   = 1;
    int unsigned stall_mode = 1;
    int unsigned stall_left = 0;
    int unsigned stall_roll;
    int unsigned cycle_count = 0;

    ordered_list_engine #(
        .DEPTH(DEPTH)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_cmd        (i_cmd),
        .i_value      (i_value),
        .i_position   (i_position),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_status     (o_status),
        .o_found      (o_found),
        .o_entry_count(o_entry_count)
    );

    always #5 i_clk = ~i_clk;

    // Result side back-pressure. A stall level is held for a random number of
    // cycles, mostly short runs with an occasional long stall.
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
        end else if (!i_rst_n || stall_mode == 0) begin
            i_out_stall = 1'b0;
        end else begin
            stall_roll = $urandom_range(0, 99);
            if (stall_roll < ((stall_mode == 2) ? 45 : 20)) begin
                i_out_stall = 1'b1;
                stall_left  = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                          : $urandom_range(0, 2);
            end else begin
                i_out_stall = 1'b0;
                stall_left  = $urandom_range(0, 4);
            end
        end
    end

    // Results are taken at the rising edge where valid is high and stall low.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_status, o_found, o_entry_count);
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (gap_mode == 0)
            return 0;
        r = $urandom_range(0, 99);
        if (r < ((gap_mode == 2) ? 40 : 75))
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 25);
    endfunction

    // Mix of full-range values, the extremes and a narrow band that repeats often.
    function automatic logic signed [VALUE_W-1:0] pick_value();
        int unsigned r;
        int          v;
        r = $urandom_range(0, 9);
        if (r < 4)
            return $urandom;
        if (r == 4) begin
            case ($urandom_range(0, 3))
                0: return VAL_MIN;
                1: return VAL_MAX;
                2: return '0;
                default: return -32'sd1;
            endcase
        end
        v = int'($urandom_range(0, 15)) - 8;
        return v;
    endfunction

    // Picks a command; grow_pct sets how often the list grows rather than shrinks.
    function automatic logic [CMD_W-1:0] pick_cmd(int unsigned grow_pct);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return ($urandom_range(0, 1) != 0) ? CMD_SPARE_6 : CMD_SPARE_7;
        if (r < 18)
            return CMD_SEARCH;
        if ($urandom_range(0, 99) < grow_pct) begin
            case ($urandom_range(0, 2))
                0: return CMD_PUSH_FRONT;
                1: return CMD_PUSH_BACK;
                default: return CMD_INSERT_AT;
            endcase
        end
        return ($urandom_range(0, 1) != 0) ? CMD_POP_FRONT : CMD_POP_BACK;
    endfunction

    // Presents one request, starting and ending at a falling edge, and holds it
    // until the block accepts it. During a gap the payload carries noise.
    task automatic send_request(input logic [CMD_W-1:0] cmd,
                                input logic signed [VALUE_W-1:0] value,
                                input logic [CNT_W-1:0] position);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid = 1'b0;
            i_cmd      = CMD_W'($urandom);
            i_value    = $urandom;
            i_position = CNT_W'($urandom);
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_cmd      = cmd;
        i_value    = value;
        i_position = position;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        sb.note_request(cmd, value, position);
        @(negedge i_clk);
    endtask

    // Corner requests: the empty list, a single entry, spare codes, filling up
    // to DEPTH starting with extreme values, and every way of hitting a full list.
    task automatic run_directed();
        logic signed [VALUE_W-1:0] v;
        send_request(CMD_POP_FRONT, VAL_MAX, CNT_W'(31));
        send_request(CMD_POP_BACK, VAL_MIN, '0);
        send_request(CMD_SEARCH, '0, '0);
        send_request(CMD_INSERT_AT, 32'sd5, CNT_W'(1));
        send_request(CMD_SPARE_6, -32'sd1, CNT_W'(31));
        send_request(CMD_SPARE_7, VAL_MAX, '0);
        send_request(CMD_INSERT_AT, VAL_MIN, '0);
        send_request(CMD_POP_BACK, '0, '0);
        for (int k = 0; k < DEPTH; k++) begin
            case (k)
                0: v = VAL_MAX;
                1: v = VAL_MIN;
                2: v = -32'sd1;
                3: v = '0;
                default: v = pick_value();
            endcase
            case (k % 3)
                0: send_request(CMD_PUSH_FRONT, v, CNT_W'($urandom));
                1: send_request(CMD_PUSH_BACK, v, CNT_W'($urandom));
                default: send_request(CMD_INSERT_AT, v, CNT_W'($urandom_range(0, k)));
            endcase
        end
        send_request(CMD_PUSH_FRONT, 32'sd1, '0);
        send_request(CMD_PUSH_BACK, 32'sd2, '0);
        send_request(CMD_INSERT_AT, 32'sd3, CNT_W'(31));
        send_request(CMD_SEARCH, VAL_MAX, '0);
        send_request(CMD_POP_FRONT, '0, '0);
    endtask

    // Random traffic in phases of differing idling. Within a phase the list is
    // driven alternately toward full and toward empty so that both ends are
    // reached over and over.
    task automatic run_random();
        logic [CMD_W-1:0]          cmd;
        logic signed [VALUE_W-1:0] value;
        logic [CNT_W-1:0]          position;
        int unsigned               count;
        for (int unsigned n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n % PHASE_LEN == 0) begin
                gap_mode   = GAP_PLAN[(n / PHASE_LEN) % 5];
                stall_mode = STALL_PLAN[(n / PHASE_LEN) % 5];
            end
            cmd   = pick_cmd(((n / 40) % 2 == 0) ? 75 : 25);
            count = sb.entry_count();
            if (cmd == CMD_SEARCH && $urandom_range(0, 99) < 60)
                value = sb.stored_value();
            else
                value = pick_value();
            if (cmd == CMD_INSERT_AT && $urandom_range(0, 99) < 85)
                position = CNT_W'($urandom_range(0, count));
            else if (cmd == CMD_INSERT_AT)
                position = CNT_W'($urandom_range(count + 1, 31));
            else
                position = CNT_W'($urandom);
            send_request(cmd, value, position);
        end
    endtask

    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        run_directed();
        run_random();
        i_in_valid = 1'b0;
        // Let every outstanding result drain, then keep watching for strays.
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.n_errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* sim.f */
+incdir+hdl
hdl/ole_pkg.sv
hdl/ole_cell.sv
hdl/ordered_list_engine.sv
dv/ordered_list_engine_tb.sv
